FILE: hw/rtl/sbox_pkg.sv
// ---------------------------------------------------------------------------
// AES S-box arithmetic package
// Field arithmetic in GF(2^8) and the affine maps used by the S-box unit.
// ---------------------------------------------------------------------------
package sbox_pkg;

    // Field polynomial x^8+x^4+x^3+x+1.
    localparam logic [8:0] FIELD_POLY       = 9'h11B;
    localparam logic [7:0] AFFINE_CONST     = 8'h63;
    localparam logic [7:0] INV_AFFINE_CONST = 8'h05;

    typedef logic [7:0] t_gf;

    // Rotate a byte left by a constant amount (1 to 7).
    function automatic t_gf rotl8(input t_gf v, input int n);
        t_gf r;
        r = t_gf'((v << n) | (v >> (8 - n)));
        return r;
    endfunction

    // Shift-and-add multiplication, eight narrow steps.
    function automatic t_gf gf_mul(input t_gf a, input t_gf b);
        logic [8:0] x;
        t_gf        acc;
        x   = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // Squaring is linear: spread the bits, then reduce the upper half.
    function automatic t_gf gf_sq(input t_gf a);
        logic [14:0] t;
        t = '0;
        for (int i = 0; i < 8; i++) begin
            t[2*i] = a[i];
        end
        for (int k = 14; k >= 8; k--) begin
            if (t[k]) begin
                t = t ^ (15'(FIELD_POLY) << (k - 8));
            end
        end
        return t[7:0];
    endfunction

    function automatic t_gf affine_fwd(input t_gf b);
        return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ AFFINE_CONST;
    endfunction

    function automatic t_gf affine_inv(input t_gf v);
        return rotl8(v, 1) ^ rotl8(v, 3) ^ rotl8(v, 6) ^ INV_AFFINE_CONST;
    endfunction

endpackage

FILE: hw/rtl/aes_sbox_forward_inverse_unit.sv
// ---------------------------------------------------------------------------
// AES forward / inverse S-box unit
// Each accepted item strobes its result on o_data_valid at the end of the
// pipeline. Throughput: one item per cycle.
// busy is tied low, since the five-stage pipeline never stalls and the
// receiver cannot hold results off. Synchronous active-low reset clears the
// valid bits only; data registers are not reset.
// ---------------------------------------------------------------------------
module aes_sbox_forward_inverse_unit
    import sbox_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_op,
    input  logic [7:0] i_data_in,
    output logic       o_data_valid,
    output logic [7:0] o_data_out
);

    // The field inverse is computed as a^254 with an addition chain:
    //   a^3   = a^2 * a
    //   a^15  = (a^3)^4 * a^3
    //   a^252 = (a^15)^16 * a^12
    //   a^254 = a^252 * a^2
    // Every stage but the first holds exactly one field multiplier; the squarings in front
    // of it are linear XOR networks. Zero maps to zero without a special case.

    // Stage 1: direction select, inverse affine map for the inverse S-box.
    logic r_v1, r_op1;
    t_gf  r_x1;

    // Stage 2: a^2 and a^3.
    logic r_v2, r_op2;
    t_gf  r_a2_2, r_a3;

    // Stage 3: a^12 and a^15.
    logic r_v3, r_op3;
    t_gf  r_a2_3, r_a12, r_a15;

    // Stage 4: a^252.
    logic r_v4, r_op4;
    t_gf  r_a2_4, r_a252;

    // Stage 5: a^254 plus the forward affine map for the forward S-box, into the output register.
    logic r_v5;
    t_gf  r_out;

    t_gf  n_x1, n_a2, n_a12, n_a240, n_inv, n_out;

    always_comb begin
        n_x1   = i_op ? affine_inv(i_data_in) : i_data_in;
        n_a2   = gf_sq(r_x1);
        n_a12  = gf_sq(gf_sq(r_a3));
        n_a240 = gf_sq(gf_sq(gf_sq(gf_sq(r_a15))));
        n_inv  = gf_mul(r_a252, r_a2_4);
        n_out  = r_op4 ? n_inv : affine_fwd(n_inv);
    end

    // Valid bits: the only control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Data path: advances every cycle, no enables needed.
    always_ff @(posedge i_clk) begin
        r_op1  <= i_op;
        r_x1   <= n_x1;

        r_op2  <= r_op1;
        r_a2_2 <= n_a2;
        r_a3   <= gf_mul(n_a2, r_x1);

        r_op3  <= r_op2;
        r_a2_3 <= r_a2_2;
        r_a12  <= n_a12;
        r_a15  <= gf_mul(n_a12, r_a3);

        r_op4  <= r_op3;
        r_a2_4 <= r_a2_3;
        r_a252 <= gf_mul(n_a240, r_a12);

        r_out  <= n_out;
    end

    assign busy         = 1'b0;
    assign o_data_valid = r_v5;
    assign o_data_out   = r_out;

`ifndef SYNTH
    // Every accepted item strobes out on o_data_valid at the end of the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_data_valid)
        else $error("accepted item did not come out after five cycles");

    // No result appears without a matching accepted item.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_data_valid |-> $past(start && !busy, 5))
        else $error("result strobe without a matching accepted item");

    // Forward substitution of zero yields the affine constant.
    a_zero_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_op && i_data_in == 8'h00) |-> ##5 (o_data_out == AFFINE_CONST))
        else $error("forward S-box of zero is wrong");

    // Inverse substitution of the affine constant yields zero.
    a_zero_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op && i_data_in == AFFINE_CONST) |-> ##5 (o_data_out == 8'h00))
        else $error("inverse S-box of the affine constant is wrong");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the AES forward / inverse S-box unit
// Drives bytes in both directions through the command interface and checks
// each strobed result against an independent GF(2^8) predictor. The run has
// directed corners, random traffic with idle bursts, a full drain, and a
// back-to-back stretch.
// ---------------------------------------------------------------------------
module testbench;
    import sbox_pkg::*;

    // Direction codes carried on i_op.
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // Low byte of the field polynomial, folded in when a doubling overflows.
    localparam logic [7:0] POLY_LOW = 8'h1B;

    // The tail wait after the drain is a comfortable margin over the unit's
    // pipeline depth.
    localparam int TAIL_CYCLES = 12;

    // About 520 items, with their idle bursts, need far fewer cycles than
    // the limit; it leaves a wide margin over the run.
    localparam int CYCLE_LIMIT = 100000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_op;
    logic [7:0] i_data_in;
    logic       o_data_valid;
    logic [7:0] o_data_out;

    // Substituted bytes still owed by the unit, oldest first.
    logic [7:0] expected_bytes[$];

    int   error_count   = 0;
    int   checked_count = 0;
    int   forward_count = 0;
    int   inverse_count = 0;
    int   cycle_count   = 0;

    // Last forward answer sent, so inverse items can be fed a known round trip.
    logic [7:0] last_forward_out = 8'h63;

    aes_sbox_forward_inverse_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_data_in    (i_data_in),
        .o_data_valid (o_data_valid),
        .o_data_out   (o_data_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Product in GF(2^8): add shifted copies of a, reducing after each doubling.
    function automatic logic [7:0] field_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = x[7] ? ((x << 1) ^ POLY_LOW) : (x << 1);
        end
        return acc;
    endfunction

    // Reciprocal as a^254 = a^2 * a^4 * ... * a^128; zero falls out as zero.
    function automatic logic [7:0] field_reciprocal(input logic [7:0] a);
        logic [7:0] power;
        logic [7:0] acc;
        power = a;
        acc   = 8'h01;
        for (int i = 0; i < 7; i++) begin
            power = field_product(power, power);
            acc   = field_product(acc, power);
        end
        return acc;
    endfunction

    // Expected output byte for one item, worked out one bit at a time.
    function automatic logic [7:0] substitute_byte(input logic op, input logic [7:0] value);
        logic [7:0] inv;
        logic [7:0] mixed;
        if (op == OP_FORWARD) begin
            inv = field_reciprocal(value);
            for (int i = 0; i < 8; i++) begin
                mixed[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8]
                         ^ inv[(i + 6) % 8] ^ inv[(i + 7) % 8] ^ AFFINE_CONST[i];
            end
            return mixed;
        end else begin
            // Undo the affine step first: bits taken at rotations by 1, 3 and 6.
            for (int i = 0; i < 8; i++) begin
                mixed[i] = value[(i + 7) % 8] ^ value[(i + 5) % 8] ^ value[(i + 2) % 8]
                         ^ INV_AFFINE_CONST[i];
            end
            return field_reciprocal(mixed);
        end
    endfunction

    // -----------------------------------------------------------------------
    // Shared stimulus tasks
    // -----------------------------------------------------------------------

    // Present one item and hold it until an edge sees start high with busy low.
    task automatic send_byte(input logic op, input logic [7:0] value);
        logic [7:0] answer;
        answer = substitute_byte(op, value);
        start     <= 1'b1;
        i_op      <= op;
        i_data_in <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_bytes.push_back(answer);
        if (op == OP_FORWARD) begin
            forward_count++;
            last_forward_out = answer;
        end else begin
            inverse_count++;
        end
    endtask

    task automatic idle_cycles(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Mostly uniform items, with one in four an inverse of the last forward answer.
    task automatic send_random_byte();
        if ($urandom_range(0, 3) == 0) begin
            send_byte(OP_INVERSE, last_forward_out);
        end else begin
            send_byte($urandom_range(0, 1) ? OP_INVERSE : OP_FORWARD, 8'($urandom_range(0, 255)));
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Corners in both directions, back to back: zero (whose reciprocal is taken
    // as zero), 0x63 which the inverse sends back to zero, all ones, single
    // bits, alternating patterns and a textbook pair.
    task automatic test_directed_corners();
        send_byte(OP_FORWARD, 8'h00);
        send_byte(OP_INVERSE, 8'h63);
        send_byte(OP_INVERSE, 8'h00);
        send_byte(OP_FORWARD, 8'hFF);
        send_byte(OP_INVERSE, 8'hFF);
        send_byte(OP_FORWARD, 8'h01);
        send_byte(OP_INVERSE, 8'h01);
        send_byte(OP_FORWARD, 8'h80);
        send_byte(OP_INVERSE, 8'h80);
        send_byte(OP_FORWARD, 8'h7F);
        send_byte(OP_INVERSE, 8'h7F);
        send_byte(OP_FORWARD, 8'h55);
        send_byte(OP_INVERSE, 8'hAA);
        send_byte(OP_FORWARD, 8'h53);
        send_byte(OP_INVERSE, 8'hED);
        send_byte(OP_FORWARD, 8'hFE);
        send_byte(OP_INVERSE, last_forward_out);
    endtask

    // Random items in stretches of 40; each stretch is either calm or gets idle
    // bursts after roughly a third of its items.
    task automatic test_random_with_gaps(input int count);
        bit gappy;
        gappy = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                gappy = $urandom_range(0, 2) != 0;
            end
            send_random_byte();
            if (gappy && $urandom_range(0, 2) == 0) begin
                idle_cycles($urandom_range(1, 13));
            end
        end
    endtask

    // Stop sending until every outstanding result has come out of the pipe.
    task automatic test_pause_until_drained();
        start <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    // Final stretch at full rate, one item on every edge.
    task automatic test_random_back_to_back(input int count);
        for (int n = 0; n < count; n++) begin
            send_random_byte();
        end
    endtask

    // -----------------------------------------------------------------------
    // Result checking
    // -----------------------------------------------------------------------

    // Results live for one cycle only, so every edge after reset is inspected.
    // An X on the strobe is treated as a result so that it cannot slip by.
    always @(posedge i_clk) begin
        if (i_rst_n && o_data_valid !== 1'b0) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result: data_out=%02h with nothing outstanding", o_data_out);
                error_count++;
            end else begin
                if (o_data_out !== expected_bytes[0]) begin
                    $error("data_out mismatch: expected %02h, actual %02h",
                           expected_bytes[0], o_data_out);
                    error_count++;
                end
                void'(expected_bytes.pop_front());
                checked_count++;
            end
        end
    end

    // Watchdog for a unit that stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_bytes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_op      <= OP_FORWARD;
        i_data_in <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_with_gaps(180);
        test_pause_until_drained();
        test_random_with_gaps(140);
        test_random_back_to_back(180);

        start <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d forward and %0d inverse items, with idle bursts, a full drain",
                 forward_count, inverse_count);
        $display("and a back-to-back stretch; %0d results checked, %0d mismatches.",
                 checked_count, error_count);
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
